[rtl/pmd_pkg.sv]
package pmd_pkg;

	localparam int KEY_DIGITS_DEF    = 10;
	localparam int MAX_GROUP_LEN_DEF = 5;
	localparam int KEY_DIGITS_MAX    = 16;

	localparam int KEY_W   = 20;
	localparam int LEN_W   = 4;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = KEY_W;

	localparam logic [KEY_W-1:0] KEY_ELEMENTS_RESET = 20'd149796;
	localparam logic [LEN_W-1:0] KEY_LENGTH_RESET   = 4'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ELEMENTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 1'b1;

	localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 7'd63;

	typedef enum logic [1:0] {
		ELEM_DOT   = 2'd0,
		ELEM_DASH  = 2'd1,
		ELEM_SPACE = 2'd2
	} elem_t;

	typedef struct packed {
		logic              produce;
		logic [CHAR_W-1:0] plain_char;
		logic              char_valid;
		logic              message_end;
	} res_t;

	function automatic logic [CHAR_W-1:0] morse_lookup(input logic [3:0] count,
		input logic [4:0] bits);
		logic [CHAR_W-1:0] ch;
		ch = UNKNOWN_CHAR;
		case (count)
			4'd1: begin
				case (bits)
					5'd0:    ch = 7'("E");
					5'd1:    ch = 7'("T");
					default: ch = UNKNOWN_CHAR;
				endcase
			end
			4'd2: begin
				case (bits)
					5'd0:    ch = 7'("I");
					5'd1:    ch = 7'("N");
					5'd2:    ch = 7'("A");
					5'd3:    ch = 7'("M");
					default: ch = UNKNOWN_CHAR;
				endcase
			end
			4'd3: begin
				case (bits)
					5'd0:    ch = 7'("S");
					5'd1:    ch = 7'("D");
					5'd2:    ch = 7'("R");
					5'd3:    ch = 7'("G");
					5'd4:    ch = 7'("U");
					5'd5:    ch = 7'("K");
					5'd6:    ch = 7'("W");
					5'd7:    ch = 7'("O");
					default: ch = UNKNOWN_CHAR;
				endcase
			end
			4'd4: begin
				case (bits)
					5'd0:    ch = 7'("H");
					5'd1:    ch = 7'("B");
					5'd2:    ch = 7'("L");
					5'd3:    ch = 7'("Z");
					5'd4:    ch = 7'("F");
					5'd5:    ch = 7'("C");
					5'd6:    ch = 7'("P");
					5'd8:    ch = 7'("V");
					5'd9:    ch = 7'("X");
					5'd11:   ch = 7'("Q");
					5'd13:   ch = 7'("Y");
					5'd14:   ch = 7'("J");
					default: ch = UNKNOWN_CHAR;
				endcase
			end
			4'd5: begin
				case (bits)
					5'd0:    ch = 7'("5");
					5'd1:    ch = 7'("6");
					5'd3:    ch = 7'("7");
					5'd7:    ch = 7'("8");
					5'd15:   ch = 7'("9");
					5'd16:   ch = 7'("4");
					5'd24:   ch = 7'("3");
					5'd28:   ch = 7'("2");
					5'd30:   ch = 7'("1");
					5'd31:   ch = 7'("0");
					default: ch = UNKNOWN_CHAR;
				endcase
			end
			default: ch = UNKNOWN_CHAR;
		endcase
		return ch;
	endfunction

endpackage

[rtl/pmd_elem.sv]
module pmd_elem #(
	parameter int KEY_DIGITS = pmd_pkg::KEY_DIGITS_DEF
) (
	input  logic [pmd_pkg::KEY_W-1:0]   key_elements,
	input  logic [pmd_pkg::LEN_W-1:0]   key_length,
	input  logic [pmd_pkg::DIGIT_W-1:0] digit,
	output pmd_pkg::elem_t              elem
);

	localparam int EXT_W = 2 * pmd_pkg::KEY_DIGITS_MAX;
	localparam int CMP_W = pmd_pkg::LEN_W + 1;

	logic [EXT_W-1:0] key_ext;
	logic [CMP_W-1:0] len_eff;
	logic [1:0]       pair;

	assign key_ext = {{(EXT_W - pmd_pkg::KEY_W){1'b0}}, key_elements};
	assign len_eff = ({1'b0, key_length} > CMP_W'(KEY_DIGITS)) ? CMP_W'(KEY_DIGITS)
		: {1'b0, key_length};
	assign pair = key_ext[{digit, 1'b0} +: 2];

	always_comb begin
		if ({1'b0, digit} >= len_eff || pair[1]) begin
			elem = pmd_pkg::ELEM_SPACE;
		end else if (pair[0]) begin
			elem = pmd_pkg::ELEM_DASH;
		end else begin
			elem = pmd_pkg::ELEM_DOT;
		end
	end

endmodule

[rtl/pmd_group.sv]
module pmd_group #(
	parameter int MAX_GROUP_LEN = pmd_pkg::MAX_GROUP_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  pmd_pkg::elem_t elem,
	input  logic           last,
	output pmd_pkg::res_t  res
);

	localparam int CNT_W = $clog2(MAX_GROUP_LEN + 1);

	logic [MAX_GROUP_LEN-1:0] elements_q, elements_upd;
	logic [CNT_W-1:0]         count_q, count_upd;
	logic                     overflow_q, overflow_upd;
	logic                     close;
	logic                     have;
	logic [pmd_pkg::CHAR_W-1:0] ch;

	always_comb begin
		elements_upd = elements_q;
		count_upd    = count_q;
		overflow_upd = overflow_q;
		if (elem != pmd_pkg::ELEM_SPACE) begin
			if (count_q < CNT_W'(MAX_GROUP_LEN)) begin
				elements_upd[count_q[$clog2(MAX_GROUP_LEN)-1:0]] =
					(elem == pmd_pkg::ELEM_DASH);
				count_upd = count_q + CNT_W'(1);
			end else begin
				overflow_upd = 1'b1;
			end
		end
	end

	assign close = (elem == pmd_pkg::ELEM_SPACE) || last;
	assign have  = close && (count_upd != '0);
	assign ch    = overflow_upd ? pmd_pkg::UNKNOWN_CHAR
		: pmd_pkg::morse_lookup(4'(count_upd), elements_upd[4:0]);

	always_comb begin
		res.produce     = have || last;
		res.plain_char  = have ? ch : '0;
		res.char_valid  = have;
		res.message_end = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elements_q <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (step) begin
			if (close) begin
				elements_q <= '0;
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				elements_q <= elements_upd;
				count_q    <= count_upd;
				overflow_q <= overflow_upd;
			end
		end
	end

endmodule

[rtl/pollux_morse_decrypt_core.sv]
// Pollux cipher decoder: one cipher digit per input transfer, Morse characters out.
// Input channel (in_valid/in_ready) carries cipher_digit and message_last.
// Output channel (out_valid/out_ready) carries plain_char, char_valid, message_end.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes key_elements
// at index 0 and key_length at index 1; write it only while the block is idle.
// A digit enters an input register, then the key lookup, group update and
// Morse table lookup run combinationally into the result register.
// Throughput: one digit per cycle while the receiver takes results; digits that
// only add a dot or dash, or repeat a letter space, give no result.
// A stalled receiver holds the result register; the input register then fills
// and in_ready drops until the result is taken.
// Reset clears the pending group, both stages and restores the key defaults.
// The item with message_last always gives a result with message_end set.
module pollux_morse_decrypt_core #(
	parameter int KEY_DIGITS    = pmd_pkg::KEY_DIGITS_DEF,
	parameter int MAX_GROUP_LEN = pmd_pkg::MAX_GROUP_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pmd_pkg::DIGIT_W-1:0]   cipher_digit,
	input  logic                          message_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pmd_pkg::CHAR_W-1:0]    plain_char,
	output logic                          char_valid,
	output logic                          message_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [pmd_pkg::KEY_W-1:0]   key_elements_q;
	logic [pmd_pkg::LEN_W-1:0]   key_length_q;
	logic                        valid_s1;
	logic [pmd_pkg::DIGIT_W-1:0] digit_s1;
	logic                        last_s1;
	logic                        advance;
	pmd_pkg::elem_t              elem;
	pmd_pkg::res_t               res;
	logic                        out_valid_q;
	logic [pmd_pkg::CHAR_W-1:0]  plain_char_q;
	logic                        char_valid_q;
	logic                        message_end_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_elements_q <= pmd_pkg::KEY_ELEMENTS_RESET;
			key_length_q   <= pmd_pkg::KEY_LENGTH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pmd_pkg::CFG_KEY_ELEMENTS: key_elements_q <= cfg_data;
				pmd_pkg::CFG_KEY_LENGTH:   key_length_q <= cfg_data[pmd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			digit_s1 <= cipher_digit;
			last_s1  <= message_last;
		end
	end

	pmd_elem #(
		.KEY_DIGITS(KEY_DIGITS)
	) u_elem (
		.key_elements(key_elements_q),
		.key_length  (key_length_q),
		.digit       (digit_s1),
		.elem        (elem)
	);

	pmd_group #(
		.MAX_GROUP_LEN(MAX_GROUP_LEN)
	) u_group (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.elem  (elem),
		.last  (last_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.produce) begin
			plain_char_q  <= res.plain_char;
			char_valid_q  <= res.char_valid;
			message_end_q <= res.message_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign plain_char  = plain_char_q;
	assign char_valid  = char_valid_q;
	assign message_end = message_end_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a held result");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !char_valid) |-> (message_end && plain_char == '0))
		else $error("result without character must be an empty end marker");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && char_valid) |-> (plain_char != '0))
		else $error("decoded character is zero");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (out_valid && message_end))
		else $error("last digit gave no end result");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 100;
	localparam logic [pmd_pkg::KEY_W-1:0] KEY_PLAIN = 20'h000E4;

	typedef struct packed {
		logic [pmd_pkg::CHAR_W-1:0] plain_char;
		logic                       char_valid;
		logic                       message_end;
	} char_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [pmd_pkg::DIGIT_W-1:0]    cipher_digit = '0;
	logic                           message_last = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [pmd_pkg::CHAR_W-1:0]     plain_char;
	logic                           char_valid;
	logic                           message_end;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [pmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	string morse_codes [36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----", "..---",
		"...--", "....-", ".....", "-....", "--...", "---..", "----."
	};
	string morse_syms = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

	logic [pmd_pkg::KEY_W-1:0] key_elems_m;
	logic [pmd_pkg::LEN_W-1:0] key_len_m;
	logic [4:0]                grp_bits;
	int                        grp_len;
	bit                        grp_ovf;

	char_result_t expected_chars[$];
	int items_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	pollux_morse_decrypt_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cipher_digit (cipher_digit),
		.message_last (message_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.plain_char   (plain_char),
		.char_valid   (char_valid),
		.message_end  (message_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic pmd_pkg::elem_t element_of_digit(
		input logic [pmd_pkg::DIGIT_W-1:0] digit);
		int span;
		int idx;
		logic [1:0] code;
		span = (key_len_m > pmd_pkg::KEY_DIGITS_DEF) ? pmd_pkg::KEY_DIGITS_DEF
			: int'(key_len_m);
		idx = int'(digit);
		if (idx >= span)
			return pmd_pkg::ELEM_SPACE;
		code = key_elems_m[2*idx +: 2];
		return code[1] ? pmd_pkg::ELEM_SPACE : pmd_pkg::elem_t'(code);
	endfunction

	function automatic void clear_group();
		grp_bits = '0;
		grp_len = 0;
		grp_ovf = 1'b0;
	endfunction

	function automatic logic [pmd_pkg::CHAR_W-1:0] char_of_group();
		string code;
		logic [4:0] bits;
		byte sym;
		if (grp_ovf)
			return pmd_pkg::UNKNOWN_CHAR;
		for (int i = 0; i < 36; i++) begin
			code = morse_codes[i];
			bits = '0;
			for (int j = 0; j < code.len(); j++)
				if (code.getc(j) == "-")
					bits[j] = 1'b1;
			if (code.len() == grp_len && bits == grp_bits) begin
				sym = morse_syms.getc(i);
				return sym[pmd_pkg::CHAR_W-1:0];
			end
		end
		return pmd_pkg::UNKNOWN_CHAR;
	endfunction

	function automatic void decode_digit(input logic [pmd_pkg::DIGIT_W-1:0] digit,
		input logic last);
		pmd_pkg::elem_t e;
		bit have;
		logic [pmd_pkg::CHAR_W-1:0] ch;
		e = element_of_digit(digit);
		have = 1'b0;
		ch = '0;
		if (e == pmd_pkg::ELEM_SPACE) begin
			if (grp_len != 0) begin
				ch = char_of_group();
				have = 1'b1;
				clear_group();
			end
		end else if (grp_len < pmd_pkg::MAX_GROUP_LEN_DEF) begin
			if (e == pmd_pkg::ELEM_DASH)
				grp_bits[grp_len] = 1'b1;
			grp_len++;
		end else begin
			grp_ovf = 1'b1;
		end
		if (last) begin
			if (!have && grp_len != 0) begin
				ch = char_of_group();
				have = 1'b1;
			end
			clear_group();
			expected_chars.push_back('{have ? ch : '0, have, 1'b1});
		end else if (have) begin
			expected_chars.push_back('{ch, 1'b1, 1'b0});
		end
	endfunction

	function automatic int digit_for(input pmd_pkg::elem_t e);
		int picks[$];
		for (int d = 0; d < 16; d++)
			if (element_of_digit(4'(d)) == e)
				picks.push_back(d);
		if (picks.size() == 0)
			return $urandom_range(15);
		return picks[$urandom_range(picks.size() - 1)];
	endfunction

	function automatic logic [pmd_pkg::DIGIT_W-1:0] hex_digit(input byte c);
		return (c >= "a") ? 4'(c - "a" + 10) : 4'(c - "0");
	endfunction

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected result: plain_char %0d char_valid %0b message_end %0b",
					plain_char, char_valid, message_end);
				mismatches++;
			end else begin
				char_result_t want;
				want = expected_chars.pop_front();
				if (plain_char !== want.plain_char) begin
					$error("plain_char expected %0d got %0d", want.plain_char, plain_char);
					mismatches++;
				end
				if (char_valid !== want.char_valid) begin
					$error("char_valid expected %0b got %0b", want.char_valid, char_valid);
					mismatches++;
				end
				if (message_end !== want.message_end) begin
					$error("message_end expected %0b got %0b", want.message_end, message_end);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_digit(input logic [pmd_pkg::DIGIT_W-1:0] digit, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		cipher_digit <= digit;
		message_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_digit(digit, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(input string s, input bit ends_message);
		for (int i = 0; i < s.len(); i++)
			send_digit(hex_digit(s.getc(i)), ends_message && i == s.len() - 1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_key(input logic [pmd_pkg::KEY_W-1:0] elems,
		input logic [pmd_pkg::LEN_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_index <= pmd_pkg::CFG_KEY_ELEMENTS;
		cfg_data <= elems;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		key_elems_m = elems;
		@(negedge clk);
		cfg_index <= pmd_pkg::CFG_KEY_LENGTH;
		cfg_data <= {16'($urandom), len};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		key_len_m = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_message();
		int digs[$];
		int n_letters;
		string code;
		n_letters = $urandom_range(1, 6);
		for (int l = 0; l < n_letters; l++) begin
			if ($urandom_range(9) < 8) begin
				code = morse_codes[$urandom_range(35)];
				for (int j = 0; j < code.len(); j++)
					digs.push_back(digit_for(code.getc(j) == "-" ? pmd_pkg::ELEM_DASH
						: pmd_pkg::ELEM_DOT));
			end else begin
				repeat ($urandom_range(1, 7))
					digs.push_back(digit_for($urandom_range(1) ? pmd_pkg::ELEM_DASH
						: pmd_pkg::ELEM_DOT));
			end
			if (l < n_letters - 1)
				repeat ($urandom_range(1, 2)) digs.push_back(digit_for(pmd_pkg::ELEM_SPACE));
		end
		case ($urandom_range(2))
			1: digs.push_back(digit_for(pmd_pkg::ELEM_SPACE));
			2: repeat (2) digs.push_back(digit_for(pmd_pkg::ELEM_SPACE));
			default: ;
		endcase
		foreach (digs[i])
			send_digit(4'(digs[i]), i == digs.size() - 1);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_digit(4'($urandom_range(15)), $urandom_range(3) == 0);
	endtask

	task automatic run_traffic_phase(input int send_pct, input int recv_pct,
		input logic [pmd_pkg::KEY_W-1:0] elems, input logic [pmd_pkg::LEN_W-1:0] len);
		int first;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		load_key(elems, len);
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			if ($urandom_range(4) == 0)
				send_noise();
			else
				send_random_message();
		end
		wait_idle();
	endtask

	task automatic test_reset_key();
		send_seq("012", 1'b0);
		send_seq("9", 1'b1);
		wait_idle();
	endtask

	task automatic test_groups();
		load_key(KEY_PLAIN, 4'd10);
		send_seq("012", 1'b0);
		send_seq("2", 1'b0);
		send_seq("111113", 1'b0);
		// six dots, closed by a digit outside the key
		send_seq("000000f", 1'b0);
		send_seq("0101", 1'b1);
		send_seq("12", 1'b1);
		send_seq("2", 1'b1);
		wait_idle();
	endtask

	task automatic test_key_length();
		load_key(KEY_PLAIN, 4'd0);
		send_seq("0", 1'b1);
		wait_idle();
		load_key(KEY_PLAIN, 4'd15);
		send_seq("9c", 1'b1);
		wait_idle();
		load_key(KEY_PLAIN, 4'd3);
		send_seq("04", 1'b1);
		wait_idle();
	endtask

	task automatic test_key_extremes();
		load_key(20'hFFFFF, 4'd10);
		send_seq("01", 1'b1);
		wait_idle();
		load_key(20'h00000, 4'd10);
		send_seq("00b", 1'b1);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(0, 0, 20'($urandom), 4'd10);
		run_traffic_phase(59, 0, 20'($urandom), 4'd15);
		run_traffic_phase(0, 59, 20'($urandom), 4'($urandom_range(1, 15)));
		run_traffic_phase(10, 10, 20'($urandom), 4'd10);
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		key_elems_m = pmd_pkg::KEY_ELEMENTS_RESET;
		key_len_m = pmd_pkg::KEY_LENGTH_RESET;
		clear_group();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_key();
		test_groups();
		test_key_length();
		test_key_extremes();
		test_random_traffic();
		repeat (10) @(negedge clk);
		if (expected_chars.size() != 0) begin
			$error("%0d expected results never arrived", expected_chars.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[pollux_morse_decrypt_core.f]
rtl/pmd_pkg.sv
rtl/pmd_elem.sv
rtl/pmd_group.sv
rtl/pollux_morse_decrypt_core.sv
bench/testbench.sv
